@@ rtl/core/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W  = 21;
  localparam int REP_W = 3;

  localparam logic [CP_W-1:0] REPL_CP = CP_W'(8'h3F);
  localparam logic [CP_W-1:0] EOS_CP  = '0;

  // One entry per accepted byte that gives results: a run of '?' results,
  // then an optional tail result.
  typedef struct packed {
    logic [REP_W-1:0] rep_count;
    logic             tail_valid;
    logic [CP_W-1:0]  tail_cp;
    logic             tail_eos;
  } cmd_t;

endpackage

@@ rtl/core/u8d_front.sv @@
// ----------------------------------------------------------------------------
// u8d_front
// Sequence tracking and byte classification; builds one command per item.
// ----------------------------------------------------------------------------
module u8d_front import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  output logic       push,
  output cmd_t       cmd
);

  logic [2:0]      expected_length, expected_length_next;
  logic [1:0]      bytes_held, bytes_held_next;
  logic [CP_W-1:0] partial_value, partial_value_next;

  logic            is_open, is_cont;
  logic [2:0]      held_inc;
  logic [CP_W-1:0] pv_shift;

  function automatic logic seq_ok(input logic [2:0] len, input logic [CP_W-1:0] cp);
    logic ok;
    if (len == 3'd2) begin
      ok = cp >= CP_W'(12'h080);
    end else if (len == 3'd3) begin
      ok = (cp >= CP_W'(12'h800)) && !((cp >= CP_W'(16'hD800)) && (cp <= CP_W'(16'hDFFF)));
    end else begin
      ok = (cp >= CP_W'(20'h10000)) && (cp <= CP_W'(21'h10FFFF));
    end
    return ok;
  endfunction

  assign is_open  = expected_length != 3'd0;
  assign is_cont  = byte_in[7:6] == 2'b10;
  assign held_inc = {1'b0, bytes_held} + 3'd1;
  assign pv_shift = {partial_value[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    expected_length_next = expected_length;
    bytes_held_next      = bytes_held;
    partial_value_next   = partial_value;
    cmd                  = '0;
    if (is_open && is_cont) begin
      if (held_inc >= expected_length) begin
        if (seq_ok(expected_length, pv_shift)) begin
          cmd.tail_valid = 1'b1;
          cmd.tail_cp    = pv_shift;
        end else begin
          cmd.rep_count = held_inc;
        end
        expected_length_next = 3'd0;
        bytes_held_next      = 2'd0;
        partial_value_next   = '0;
      end else begin
        bytes_held_next    = held_inc[1:0];
        partial_value_next = pv_shift;
      end
    end else begin
      cmd.rep_count        = is_open ? {1'b0, bytes_held} : 3'd0;
      expected_length_next = 3'd0;
      bytes_held_next      = 2'd0;
      partial_value_next   = '0;
      if (byte_in == 8'h00) begin
        cmd.tail_valid = 1'b1;
        cmd.tail_cp    = EOS_CP;
        cmd.tail_eos   = 1'b1;
      end else if (byte_in[7] == 1'b0) begin
        cmd.tail_valid = 1'b1;
        cmd.tail_cp    = CP_W'(byte_in);
      end else if (byte_in[7:5] == 3'b110) begin
        expected_length_next = 3'd2;
        bytes_held_next      = 2'd1;
        partial_value_next   = CP_W'(byte_in[4:0]);
      end else if (byte_in[7:4] == 4'b1110) begin
        expected_length_next = 3'd3;
        bytes_held_next      = 2'd1;
        partial_value_next   = CP_W'(byte_in[3:0]);
      end else if (byte_in[7:3] == 5'b11110) begin
        expected_length_next = 3'd4;
        bytes_held_next      = 2'd1;
        partial_value_next   = CP_W'(byte_in[2:0]);
      end else begin
        // stray continuation or F8..FF lead
        cmd.rep_count = cmd.rep_count + 3'd1;
      end
    end
  end

  assign push = accept && ((cmd.rep_count != 3'd0) || cmd.tail_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= 3'd0;
      bytes_held      <= 2'd0;
      partial_value   <= '0;
    end else if (accept) begin
      expected_length <= expected_length_next;
      bytes_held      <= bytes_held_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule

@@ rtl/core/u8d_queue.sv @@
// ----------------------------------------------------------------------------
// u8d_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module u8d_queue import u8d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/u8d_back.sv @@
// ----------------------------------------------------------------------------
// u8d_back
// Expands queued commands into registered results, one per cycle if not stalled.
// ----------------------------------------------------------------------------
module u8d_back import u8d_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cmd_t            head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            is_replacement,
  output logic            end_of_string,
  output logic            last_of_run
);

  logic [REP_W-1:0] idx;
  logic             advance, in_rep, is_last;

  assign advance = head_valid && (!out_valid || out_ready);
  assign in_rep  = idx < head_cmd.rep_count;
  assign is_last = in_rep ? ((idx == head_cmd.rep_count - REP_W'(1)) && !head_cmd.tail_valid)
                          : 1'b1;
  assign pop     = advance && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + REP_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      code_point     <= in_rep ? REPL_CP : head_cmd.tail_cp;
      is_replacement <= in_rep;
      end_of_string  <= !in_rep && head_cmd.tail_eos;
      last_of_run    <= is_last;
    end
  end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with '?' replacement.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the command queue has room. Each result
// leaves through the output register at one per cycle while out_ready
// allows, so a byte that gives k results (up to four: flushed bytes plus its
// own result) holds the back end until all k have left; the QUEUE_DEPTH-entry
// command queue absorbs such bursts, and the input stalls only when it fills.
// Bytes that give no result (leads, inner continuations) never reach the
// queue. Results pass through the command queue, then the output register.
module utf8_stream_decoder import u8d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      byte_in,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] code_point,
  output logic            is_replacement,
  output logic            end_of_string,
  output logic            last_of_run
);

  logic accept, push, pop, full, head_valid;
  cmd_t cmd, head_cmd;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  u8d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (byte_in),
    .push    (push),
    .cmd     (cmd)
  );

  u8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  u8d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code_point     (code_point),
    .is_replacement (is_replacement),
    .end_of_string  (end_of_string),
    .last_of_run    (last_of_run)
  );

endmodule
